@@ hw/rtl/tpc_pkg.sv @@
`timescale 1ns / 1ps

package tpc_pkg;

    // Pixel and result field widths
    localparam int CH_W      = 8;
    localparam int PX_W      = 4 * CH_W;
    localparam int KIND_W    = 3;

    // Register file
    localparam int ADDR_W    = 4;
    localparam int DATA_W    = 32;
    localparam int REG_SIDE_W = 13;
    localparam int CNT_W     = 24;

    localparam int MAX_SIDE_DEF = 4096;

    localparam logic [REG_SIDE_W-1:0] WIDTH_RST  = REG_SIDE_W'(128);
    localparam logic [REG_SIDE_W-1:0] HEIGHT_RST = REG_SIDE_W'(128);
    localparam logic [CNT_W-1:0]      LIMIT_RST  = CNT_W'(1000);
    localparam logic [CNT_W-1:0]      CNT_MAX    = {CNT_W{1'b1}};

    // Marker colours, RGB
    localparam logic [CH_W-1:0] MK0_R = 8'd10;
    localparam logic [CH_W-1:0] MK0_G = 8'd5;
    localparam logic [CH_W-1:0] MK0_B = 8'd5;
    localparam logic [CH_W-1:0] MK1_R = 8'd21;
    localparam logic [CH_W-1:0] MK1_G = 8'd10;
    localparam logic [CH_W-1:0] MK1_B = 8'd10;

    // Magenta as packed {b,g,r}
    localparam logic [3*CH_W-1:0] MAGENTA_BGR = 24'hFF00FF;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_FONTS  = 2'd2,
        REG_LIMIT  = 2'd3
    } t_reg_idx;

    typedef enum logic [KIND_W-1:0] {
        KIND_PIXEL   = 3'd0,
        KIND_MAGENTA = 3'd1,
        KIND_SOLID   = 3'd2,
        KIND_FONT    = 3'd3,
        KIND_SCRAP   = 3'd4,
        KIND_PROC    = 3'd5,
        KIND_MOVIE   = 3'd6,
        KIND_NONE    = 3'd7
    } t_kind;

    // Bitmap shape tests, fixed while a bitmap streams
    typedef struct packed {
        logic single;
        logic square;
        logic pow_side;
        logic proc_side;
        logic movie;
        logic fonts_off;
    } t_shape;

    // Decoded pixel from the input stage
    typedef struct packed {
        logic            gray;
        logic            black;
        logic            white;
        logic            alpha_nz;
        logic            mark0;
        logic            mark1;
        logic [PX_W-1:0] px;      // {a,b,g,r}
    } t_pix_info;

    typedef struct packed {
        logic differs;
        logic font_fail;
        logic font_black;
        logic font_white;
        logic font_other;
        logic font_alpha;
        logic scrap_fail;
        logic scrap_white;
        logic scrap_black;
        logic scrap_gray;
    } t_flags;

endpackage

@@ hw/rtl/tpc_pix_if.sv @@
`timescale 1ns / 1ps

interface tpc_pix_if;
    import tpc_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic [CH_W-1:0] alpha;

    modport source (output valid, red, green, blue, alpha, input ready);
    modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

@@ hw/rtl/tpc_res_if.sv @@
`timescale 1ns / 1ps

interface tpc_res_if;
    import tpc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   corner_red;
    logic [CH_W-1:0]   corner_green;
    logic [CH_W-1:0]   corner_blue;
    logic [CH_W-1:0]   corner_alpha;

    modport source (output valid, kind, corner_red, corner_green, corner_blue, corner_alpha,
                    input ready);
    modport sink   (input valid, kind, corner_red, corner_green, corner_blue, corner_alpha,
                    output ready);
endinterface

@@ hw/rtl/tpc_cfg.sv @@
`timescale 1ns / 1ps

module tpc_cfg #(
    parameter int  MAX_SIDE = tpc_pkg::MAX_SIDE_DEF,
    localparam int SIDE_W   = $clog2(MAX_SIDE) + 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
    output logic [tpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready,
    output logic                        o_wr,
    output logic [SIDE_W-1:0]           o_w,
    output logic [SIDE_W-1:0]           o_h,
    output logic [SIDE_W-1:0]           o_half_lim,
    output tpc_pkg::t_shape             o_shape,
    output logic [tpc_pkg::CNT_W-1:0]   o_limit
);
    import tpc_pkg::*;

    logic [REG_SIDE_W-1:0] r_width;
    logic [REG_SIDE_W-1:0] r_height;
    logic                  r_fonts_off;
    logic [CNT_W-1:0]      r_limit;
    t_reg_idx              w_idx;
    logic                  w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[ADDR_W-1:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width     <= WIDTH_RST;
            r_height    <= HEIGHT_RST;
            r_fonts_off <= 1'b0;
            r_limit     <= LIMIT_RST;
        end else if (w_wr) begin
            case (w_idx)
                REG_WIDTH:  r_width     <= pwdata[REG_SIDE_W-1:0];
                REG_HEIGHT: r_height    <= pwdata[REG_SIDE_W-1:0];
                REG_FONTS:  r_fonts_off <= pwdata[0];
                REG_LIMIT:  r_limit     <= pwdata[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (w_idx)
            REG_WIDTH:  prdata = DATA_W'(r_width);
            REG_HEIGHT: prdata = DATA_W'(r_height);
            REG_FONTS:  prdata = DATA_W'(r_fonts_off);
            REG_LIMIT:  prdata = DATA_W'(r_limit);
            default:    prdata = '0;
        endcase
    end

    // Effective sides: zero acts as one, clamp to MAX_SIDE
    function automatic logic [SIDE_W-1:0] eff_side(input logic [REG_SIDE_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (32'(v) > 32'(MAX_SIDE)) begin
            res = SIDE_W'(MAX_SIDE);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

    assign o_w        = eff_side(r_width);
    assign o_h        = eff_side(r_height);
    assign o_half_lim = (o_w >> 1) + SIDE_W'(1);
    assign o_limit    = r_limit;
    assign o_wr       = w_wr;

    // Shape tests
    always_comb begin
        o_shape.single    = (o_w == SIDE_W'(1)) && (o_h == SIDE_W'(1));
        o_shape.square    = (o_w == o_h);
        o_shape.proc_side = (o_w == SIDE_W'(128)) || (o_w == SIDE_W'(256)) ||
                            (o_w == SIDE_W'(512));
        o_shape.pow_side  = o_shape.proc_side || (o_w == SIDE_W'(1024));
        o_shape.movie     = ((o_w == SIDE_W'(200)) && (o_h == SIDE_W'(200))) ||
                            ((o_w == SIDE_W'(300)) && (o_h == SIDE_W'(160)));
        o_shape.fonts_off = r_fonts_off;
    end

endmodule

@@ hw/rtl/tpc_decode.sv @@
`timescale 1ns / 1ps

module tpc_decode (
    input  logic               i_clk,
    input  logic               i_rst_n,
    tpc_pix_if.sink            i_pix,
    input  logic               i_take,
    output logic               o_vld,
    output tpc_pkg::t_pix_info o_info
);
    import tpc_pkg::*;

    logic      r_vld;
    t_pix_info r_info;
    t_pix_info n_info;
    logic      w_acc;

    assign i_pix.ready = !r_vld || i_take;
    assign w_acc       = i_pix.valid && i_pix.ready;

    // Per-pixel color tests; gray, black, white and markers use RGB only
    always_comb begin
        n_info.gray     = (i_pix.red == i_pix.green) && (i_pix.green == i_pix.blue);
        n_info.black    = (i_pix.red == '0) && (i_pix.green == '0) && (i_pix.blue == '0);
        n_info.white    = (i_pix.red == '1) && (i_pix.green == '1) && (i_pix.blue == '1);
        n_info.alpha_nz = (i_pix.alpha != '0);
        n_info.mark0    = (i_pix.red == MK0_R) && (i_pix.green == MK0_G) &&
                          (i_pix.blue == MK0_B);
        n_info.mark1    = (i_pix.red == MK1_R) && (i_pix.green == MK1_G) &&
                          (i_pix.blue == MK1_B);
        n_info.px       = {i_pix.alpha, i_pix.blue, i_pix.green, i_pix.red};
    end

    // Input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (w_acc) begin
            r_vld <= 1'b1;
        end else if (i_take) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_info <= n_info;
        end
    end

    assign o_vld  = r_vld;
    assign o_info = r_info;

endmodule

@@ hw/rtl/tpc_accum.sv @@
`timescale 1ns / 1ps

module tpc_accum #(
    parameter int  MAX_SIDE = tpc_pkg::MAX_SIDE_DEF,
    localparam int POS_W    = $clog2(MAX_SIDE),
    localparam int SIDE_W   = POS_W + 1
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_clr,
    input  logic [SIDE_W-1:0]         i_w,
    input  logic [SIDE_W-1:0]         i_h,
    input  logic [SIDE_W-1:0]         i_half_lim,
    input  tpc_pkg::t_shape           i_shape,
    input  logic [tpc_pkg::CNT_W-1:0] i_limit,
    input  logic                      i_vld,
    input  tpc_pkg::t_pix_info        i_info,
    output logic                      o_take,
    tpc_res_if.source                 o_res
);
    import tpc_pkg::*;

    // Frame state
    logic [POS_W-1:0] r_col;
    logic [POS_W-1:0] r_row;
    logic [PX_W-1:0]  r_corner;
    logic [CNT_W-1:0] r_cnt0;
    logic [CNT_W-1:0] r_cnt1;
    t_flags           r_flags;

    // Result register
    logic             r_out_vld;
    t_kind            r_kind;
    logic [PX_W-1:0]  r_out_px;

    logic [PX_W-1:0]  n_corner;
    logic [CNT_W-1:0] n_cnt0;
    logic [CNT_W-1:0] n_cnt1;
    t_flags           n_flags;
    t_kind            n_kind;
    logic             w_first;
    logic             w_col_last;
    logic             w_row_last;
    logic             w_font;
    logic             w_scrap;

    assign o_take  = i_vld && (!r_out_vld || o_res.ready);
    assign w_first = (r_col == '0) && (r_row == '0);

    assign w_col_last = !(({1'b0, r_col} + SIDE_W'(1)) < i_w);
    assign w_row_last = !(({1'b0, r_row} + SIDE_W'(1)) < i_h);

    // Flag and counter update for this pixel
    always_comb begin
        n_corner = w_first ? i_info.px : r_corner;
        n_flags  = r_flags;
        if (!w_first && (i_info.px != r_corner)) begin
            n_flags.differs = 1'b1;
        end
        if (!i_info.gray && ({1'b0, r_col} > i_half_lim)) begin
            n_flags.font_fail = 1'b1;
        end
        if (i_info.black) begin
            n_flags.font_black = 1'b1;
        end else if (i_info.white) begin
            n_flags.font_white = 1'b1;
        end else begin
            n_flags.font_other = 1'b1;
        end
        if (i_info.alpha_nz) begin
            n_flags.font_alpha = 1'b1;
        end
        if (!i_info.gray) begin
            n_flags.scrap_fail = 1'b1;
        end
        if (i_info.white) begin
            n_flags.scrap_white = 1'b1;
        end else if (i_info.black) begin
            n_flags.scrap_black = 1'b1;
        end else begin
            n_flags.scrap_gray = 1'b1;
        end
        // saturating marker counts
        n_cnt0 = (i_info.mark0 && (r_cnt0 != CNT_MAX)) ? r_cnt0 + CNT_W'(1) : r_cnt0;
        n_cnt1 = (i_info.mark1 && (r_cnt1 != CNT_MAX)) ? r_cnt1 + CNT_W'(1) : r_cnt1;
    end

    // Class cascade on the state after this pixel
    always_comb begin
        w_font  = !i_shape.fonts_off && i_shape.square && i_shape.pow_side &&
                  !n_flags.font_fail && (n_flags.font_black || n_flags.font_white) &&
                  (n_flags.font_other || n_flags.font_alpha);
        w_scrap = i_shape.square && i_shape.pow_side && !n_flags.scrap_fail &&
                  (n_flags.scrap_white || n_flags.scrap_black) && n_flags.scrap_gray;
        if (i_shape.single) begin
            n_kind = KIND_PIXEL;
        end else if (!n_flags.differs) begin
            n_kind = (n_corner[3*CH_W-1:0] == MAGENTA_BGR) ? KIND_MAGENTA : KIND_SOLID;
        end else if (w_font) begin
            n_kind = KIND_FONT;
        end else if (w_scrap) begin
            n_kind = KIND_SCRAP;
        end else if (i_shape.square && i_shape.proc_side &&
                     ((n_cnt0 > i_limit) || (n_cnt1 > i_limit))) begin
            n_kind = KIND_PROC;
        end else if (i_shape.movie) begin
            n_kind = KIND_MOVIE;
        end else begin
            n_kind = KIND_NONE;
        end
    end

    // Frame state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr || (o_take && w_col_last && w_row_last)) begin
            r_col    <= '0;
            r_row    <= '0;
            r_corner <= '0;
            r_cnt0   <= '0;
            r_cnt1   <= '0;
            r_flags  <= '0;
        end else if (o_take) begin
            r_corner <= n_corner;
            r_cnt0   <= n_cnt0;
            r_cnt1   <= n_cnt1;
            r_flags  <= n_flags;
            if (w_col_last) begin
                r_col <= '0;
                r_row <= r_row + POS_W'(1);
            end else begin
                r_col <= r_col + POS_W'(1);
            end
        end
    end

    // Result register, one transaction per bitmap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (o_take && w_col_last && w_row_last) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && w_col_last && w_row_last) begin
            r_kind   <= n_kind;
            r_out_px <= n_corner;
        end
    end

    assign o_res.valid        = r_out_vld;
    assign o_res.kind         = r_kind;
    assign o_res.corner_red   = r_out_px[CH_W-1:0];
    assign o_res.corner_green = r_out_px[2*CH_W-1:CH_W];
    assign o_res.corner_blue  = r_out_px[3*CH_W-1:2*CH_W];
    assign o_res.corner_alpha = r_out_px[4*CH_W-1:3*CH_W];

endmodule

@@ hw/rtl/texture_pixel_classifier.sv @@
`timescale 1ns / 1ps

// Channel   Dir  Payload                                   Transaction
// i_pix     in   red, green, blue, alpha (8b each)         valid & ready, one pixel
// o_res     out  kind (3b), corner_red/green/blue/alpha    valid & ready, one per bitmap
// apb       in   psel/penable/pwrite, paddr[3:0], pwdata   write at access phase
//
// One pixel per cycle sustained unless a result waits; the input stage and the result
// register each hold one transaction, and the last pixel's class passes through the
// input stage, then the result register. While a result waits there no pixel is taken, so
// the input stalls once the input stage is full. Synchronous active-low reset
// clears position, counters, flags and both valids; registers return to
// 128 x 128, fonts on, limit 1000. Any register write restarts the bitmap.

module texture_pixel_classifier #(
    parameter int MAX_SIDE = tpc_pkg::MAX_SIDE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    tpc_pix_if.sink                     i_pix,
    tpc_res_if.source                   o_res,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [tpc_pkg::ADDR_W-1:0]  paddr,
    input  logic [tpc_pkg::DATA_W-1:0]  pwdata,
    output logic [tpc_pkg::DATA_W-1:0]  prdata,
    output logic                        pready
);
    import tpc_pkg::*;

    localparam int SIDE_W = $clog2(MAX_SIDE) + 1;

    logic              w_clr;
    logic [SIDE_W-1:0] w_w;
    logic [SIDE_W-1:0] w_h;
    logic [SIDE_W-1:0] w_half_lim;
    t_shape            w_shape;
    logic [CNT_W-1:0]  w_limit;
    logic              w_dec_vld;
    t_pix_info         w_info;
    logic              w_take;

    // Register file
    tpc_cfg #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_wr       (w_clr),
        .o_w        (w_w),
        .o_h        (w_h),
        .o_half_lim (w_half_lim),
        .o_shape    (w_shape),
        .o_limit    (w_limit)
    );

    // Pixel input stage
    tpc_decode u_dec (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pix   (i_pix),
        .i_take  (w_take),
        .o_vld   (w_dec_vld),
        .o_info  (w_info)
    );

    // Frame state and class
    tpc_accum #(
        .MAX_SIDE (MAX_SIDE)
    ) u_acc (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_clr      (w_clr),
        .i_w        (w_w),
        .i_h        (w_h),
        .i_half_lim (w_half_lim),
        .i_shape    (w_shape),
        .i_limit    (w_limit),
        .i_vld      (w_dec_vld),
        .i_info     (w_info),
        .o_take     (w_take),
        .o_res      (o_res)
    );

`ifndef ASSERT_OFF
    // A pixel in the input stage stays until the frame logic takes it
    a_dec_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_dec_vld && !w_take) |=> w_dec_vld)
        else $error("input stage dropped a pixel");

    // The frame logic only takes a pixel when the result register can accept
    a_take_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_take |-> (!o_res.valid || o_res.ready))
        else $error("pixel taken while result register is blocked");

    // Reset empties both stages
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_res.valid && !w_dec_vld))
        else $error("stage valid after reset");
`endif

endmodule
